/* src/bsp_pkg.sv */
package bsp_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam int BYTE_W  = 8;
  localparam int PEND_W  = 7;
  localparam int ACC_W   = PEND_W + VALUE_W;
  localparam int NB_W    = 3;
  localparam int IDX_W   = 2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] aligned;
    logic [NB_W-1:0]    nbytes;
    logic               err;
  } job_t;

endpackage

/* src/bsp_front.sv */
module bsp_front import bsp_pkg::*; #(
  parameter int COUNT_LIMIT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [VALUE_W-1:0] value,
  input  logic [COUNT_W-1:0] bit_count,
  output logic               push,
  output job_t               job
);

  logic [PEND_W-1:0] pending_bits;
  logic [2:0]        pending_count;

  logic [ACC_W-1:0]   mask;
  logic [ACC_W-1:0]   acc;
  logic [COUNT_W-1:0] total;
  logic [2:0]         left;
  logic [NB_W-1:0]    nbytes;
  logic               bad;
  logic [PEND_W-1:0]  left_mask;

  always_comb begin
    bad       = (bit_count == '0) || (bit_count > COUNT_W'(COUNT_LIMIT));
    mask      = ~({ACC_W{1'b1}} << bit_count);
    acc       = ({{(ACC_W-PEND_W){1'b0}}, pending_bits} << bit_count)
                | ({{PEND_W{1'b0}}, value} & mask);
    total     = COUNT_W'(pending_count) + bit_count;
    nbytes    = total[5:3];
    left      = total[2:0];
    left_mask = PEND_W'((8'd1 << left) - 8'd1);

    job.aligned = bad ? '0 : VALUE_W'(acc >> left);
    job.nbytes  = bad ? NB_W'(1) : nbytes;
    job.err     = bad;
    push        = accept && (bad || (nbytes != '0));
  end

  // leftover bits stay right aligned
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (accept && !bad) begin
      pending_bits  <= acc[PEND_W-1:0] & left_mask;
      pending_count <= left;
    end
  end

endmodule

/* src/bsp_queue.sv */
module bsp_queue import bsp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == CNT_W'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* src/bsp_back.sv */
module bsp_back import bsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  job_t              head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic              out_status
);

  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  sel;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_last;
  logic              load;

  always_comb begin
    sel      = IDX_W'(head.nbytes - NB_W'(1) - NB_W'(idx));
    cur_byte = head.err ? '0 : head.aligned[{sel, 3'b000} +: BYTE_W];
    cur_last = head.err || (NB_W'(idx) == head.nbytes - NB_W'(1));
    load     = head_valid && (!out_valid || out_ready);
    pop      = load && cur_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= cur_last ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= cur_byte;
      out_last   <= cur_last;
      out_status <= head.err ? STATUS_ERR : STATUS_OK;
    end
  end

endmodule

/* src/bitstream_packer_unit.sv */
// the first byte of an item passes through the job queue and then the output register
// throughput: one byte per cycle while m_tready is high and a job is queued, set by the
// single-byte output register; a full 32-bit item's four bytes leave one at a time
// a queue of QUEUE_DEPTH jobs sits between the bit accumulator and the byte emitter
// reset clears pending bits, the job queue and the output valid
module bitstream_packer_unit import bsp_pkg::*; #(
  parameter int MAX_BITS    = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], bit_count[37:32], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,
  output logic        m_tuser    // status[0]
);

  localparam int COUNT_LIMIT = (MAX_BITS < 32) ? MAX_BITS : 32;

  logic accept;
  logic push;
  job_t push_job;
  job_t head;
  logic empty;
  logic full;
  logic pop;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  bsp_front #(
    .COUNT_LIMIT(COUNT_LIMIT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .value(s_tdata[VALUE_W-1:0]),
    .bit_count(s_tdata[VALUE_W+COUNT_W-1:VALUE_W]),
    .push(push),
    .job(push_job)
  );

  bsp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .pop(pop),
    .head(head),
    .empty(empty),
    .full(full)
  );

  bsp_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .head_valid(!empty),
    .pop(pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_byte(m_tdata),
    .out_last(m_tlast),
    .out_status(m_tuser)
  );

endmodule

/* src/bsp_checker.sv */
module bsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // a stalled item holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output item changed while stalled");

  // an error item is a lone zero byte closing its run
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
    else $error("bad error item");

  // nothing shows right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // output valid rises only for an accepted item that has passed through the job queue
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("output item with no source");

endmodule

bind bitstream_packer_unit bsp_checker u_bsp_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tlast(m_tlast),
  .m_tuser(m_tuser)
);
